// ===== rtl/core/irpdt_pkg.sv =====
package irpdt_pkg;

  localparam int unsigned TickW     = 16;
  localparam int unsigned RegIdxW   = 3;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned BitIdxW   = 3;
  localparam int unsigned MaxBytesDef = 16;

  localparam logic [TickW-1:0] LeaderMarkRst  = 16'd9000;
  localparam logic [TickW-1:0] LeaderSpaceRst = 16'd4560;
  localparam logic [TickW-1:0] BitMarkRst     = 16'd500;
  localparam logic [TickW-1:0] ZeroSpaceRst   = 16'd500;
  localparam logic [TickW-1:0] OneSpaceRst    = 16'd1690;
  localparam logic [TickW-1:0] StopMarkRst    = 16'd560;

  typedef enum logic [RegIdxW-1:0] {
    REG_LEADER_MARK  = 3'd0,
    REG_LEADER_SPACE = 3'd1,
    REG_BIT_MARK     = 3'd2,
    REG_ZERO_SPACE   = 3'd3,
    REG_ONE_SPACE    = 3'd4,
    REG_STOP_MARK    = 3'd5
  } reg_idx_e;

  typedef enum logic [2:0] {
    PH_IDLE        = 3'd0,
    PH_LEAD_MARK   = 3'd1,
    PH_LEAD_SPACE  = 3'd2,
    PH_BIT_MARK    = 3'd3,
    PH_BIT_SPACE   = 3'd4,
    PH_STOP_MARK   = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_BUSY = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_PUSH = 1'b1
  } op_e;

  typedef struct packed {
    logic [TickW-1:0] leader_mark;
    logic [TickW-1:0] leader_space;
    logic [TickW-1:0] bit_mark;
    logic [TickW-1:0] zero_space;
    logic [TickW-1:0] one_space;
    logic [TickW-1:0] stop_mark;
  } timing_cfg_t;

  typedef struct packed {
    status_e status;
    logic    done;
    logic    busy;
    logic    level;
  } result_t;

  typedef struct packed {
    logic wr;
    logic rd;
  } mem_ctl_t;

  // Active-low line: marks drive 0, spaces and idle drive 1.
  function automatic logic ph_level(phase_e ph);
    logic lvl;
    case (ph)
      PH_LEAD_MARK, PH_BIT_MARK, PH_STOP_MARK: lvl = 1'b0;
      default:                                 lvl = 1'b1;
    endcase
    return lvl;
  endfunction

endpackage

// ===== rtl/core/irpdt_frame_mem.sv =====
module irpdt_frame_mem #(
  parameter int unsigned MAX_BYTES = irpdt_pkg::MaxBytesDef,
  parameter int unsigned AW        = 4
) (
  input  logic                      clk_i,
  input  irpdt_pkg::mem_ctl_t       ctl_i,
  input  logic [AW-1:0]             addr_i,
  input  logic [irpdt_pkg::ByteW-1:0] wdata_i,
  output logic [irpdt_pkg::ByteW-1:0] rdata_o
);
  import irpdt_pkg::*;

  logic [ByteW-1:0] mem_q [MAX_BYTES];
  logic [ByteW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr) begin
      mem_q[addr_i] <= wdata_i;
    end
  end

  // Read data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (ctl_i.rd) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/irpdt_seq.sv =====
module irpdt_seq #(
  parameter int unsigned MAX_BYTES = irpdt_pkg::MaxBytesDef,
  parameter int unsigned AW        = 4
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        acc_i,
  input  logic                        op_i,
  input  logic [irpdt_pkg::ByteW-1:0] data_i,
  input  logic                        last_i,
  input  irpdt_pkg::timing_cfg_t      cfg_i,
  output logic                        stall_o,
  output irpdt_pkg::result_t          res_o,
  output irpdt_pkg::mem_ctl_t         mem_ctl_o,
  output logic [AW-1:0]               mem_addr_o,
  output logic [irpdt_pkg::ByteW-1:0] mem_wdata_o,
  input  logic [irpdt_pkg::ByteW-1:0] mem_rdata_i
);
  import irpdt_pkg::*;

  localparam int unsigned CW = $clog2(MAX_BYTES + 1);

  phase_e             phase_q, phase_d;
  logic [TickW-1:0]   tick_q, tick_d;
  logic [CW-1:0]      cnt_q, cnt_d;
  logic [CW-1:0]      idx_q, idx_d;
  logic [BitIdxW-1:0] bit_q, bit_d;
  logic               fetch_q, fetch_d;

  logic             is_push, is_tick, buf_full, push_ok, tick_act, phase_end, cur_bit;
  logic [TickW-1:0] len_sel, len;
  logic [CW-1:0]    idx_nx;

  assign is_push  = acc_i && (op_i == OP_PUSH);
  assign is_tick  = acc_i && (op_i == OP_TICK);
  assign buf_full = (cnt_q >= CW'(MAX_BYTES));
  assign push_ok  = is_push && (phase_q == PH_IDLE) && !buf_full;
  assign tick_act = is_tick && (phase_q != PH_IDLE);
  assign cur_bit  = mem_rdata_i[bit_q];
  assign idx_nx   = idx_q + CW'(1);

  always_comb begin
    case (phase_q)
      PH_LEAD_MARK:  len_sel = cfg_i.leader_mark;
      PH_LEAD_SPACE: len_sel = cfg_i.leader_space;
      PH_BIT_MARK:   len_sel = cfg_i.bit_mark;
      PH_BIT_SPACE:  len_sel = cur_bit ? cfg_i.one_space : cfg_i.zero_space;
      default:       len_sel = cfg_i.stop_mark;
    endcase
  end

  // A zero length counts as one tick.
  assign len       = (len_sel == '0) ? TickW'(1) : len_sel;
  assign phase_end = ({1'b0, tick_q} + (TickW+1)'(1)) >= {1'b0, len};

  // Next state
  always_comb begin
    phase_d = phase_q;
    tick_d  = tick_q;
    cnt_d   = cnt_q;
    idx_d   = idx_q;
    bit_d   = bit_q;
    fetch_d = 1'b0;
    if (push_ok) begin
      cnt_d = cnt_q + CW'(1);
      if (last_i) begin
        phase_d = PH_LEAD_MARK;
        tick_d  = '0;
        idx_d   = '0;
        bit_d   = '0;
        fetch_d = 1'b1;
      end
    end else if (tick_act) begin
      if (!phase_end) begin
        tick_d = tick_q + TickW'(1);
      end else begin
        tick_d = '0;
        case (phase_q)
          PH_LEAD_MARK:  phase_d = PH_LEAD_SPACE;
          PH_LEAD_SPACE: phase_d = PH_BIT_MARK;
          PH_BIT_MARK:   phase_d = PH_BIT_SPACE;
          PH_BIT_SPACE: begin
            bit_d = bit_q + BitIdxW'(1);
            if (bit_q == '1) begin
              idx_d = idx_nx;
              if (idx_nx >= cnt_q) begin
                phase_d = PH_STOP_MARK;
              end else begin
                phase_d = PH_BIT_MARK;
                fetch_d = 1'b1;
              end
            end else begin
              phase_d = PH_BIT_MARK;
            end
          end
          default: begin
            phase_d = PH_IDLE;
            cnt_d   = '0;
            idx_d   = '0;
            bit_d   = '0;
          end
        endcase
      end
    end
  end

  // Outputs
  always_comb begin
    res_o        = '0;
    res_o.status = ST_OK;
    if (is_push) begin
      res_o.level = ph_level(phase_d);
      res_o.busy  = (phase_d != PH_IDLE);
      if (phase_q != PH_IDLE) begin
        res_o.status = ST_BUSY;
      end else if (buf_full) begin
        res_o.status = ST_FULL;
      end
    end else begin
      res_o.level = ph_level(phase_q);
      res_o.busy  = (phase_q != PH_IDLE);
      res_o.done  = tick_act && (phase_q == PH_STOP_MARK) && phase_end;
    end
    mem_ctl_o.wr = push_ok;
    mem_ctl_o.rd = fetch_q;
    mem_addr_o   = fetch_q ? idx_q[AW-1:0] : cnt_q[AW-1:0];
    mem_wdata_o  = data_i;
  end

  assign stall_o = fetch_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      tick_q  <= '0;
      cnt_q   <= '0;
      idx_q   <= '0;
      bit_q   <= '0;
      fetch_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      tick_q  <= tick_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      bit_q   <= bit_d;
      fetch_q <= fetch_d;
    end
  end

endmodule

// ===== rtl/core/ir_pulse_distance_transmitter_core.sv =====
// Channel   Dir  Beat contents
// s_axis    in   tdata: data_byte[7:0]; tuser: op; tlast: last_byte
// m_axis    out  tdata: line_level, busy_res, frame_done, push_status[1:0], 3 zero bits
// cfg       in   cfg_we_i / cfg_idx_i / cfg_wdata_i, one register write per cycle
//
// One input beat per cycle while tready is high, one result beat for each input beat.
// A frame start and every byte boundary cost a stall while the next
// frame byte is read from the single-port frame buffer (registered read data).
// Reset clears the sequencer and valid flag; buffer and result data are not cleared.
// Input is taken when not fetching and the output register is empty or being drained.
module ir_pulse_distance_transmitter_core #(
  parameter int unsigned MAX_BYTES = irpdt_pkg::MaxBytesDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [7:0]                    s_axis_tdata_i,   // data_byte[7:0]
  input  logic                          s_axis_tuser_i,   // op
  input  logic                          s_axis_tlast_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // line_level, busy_res, frame_done, push_status[1:0], zero padding
  output logic [7:0]                    m_axis_tdata_o,
  input  logic                          cfg_we_i,
  input  logic [irpdt_pkg::RegIdxW-1:0] cfg_idx_i,
  input  logic [irpdt_pkg::TickW-1:0]   cfg_wdata_i
);
  import irpdt_pkg::*;

  localparam int unsigned AW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;

  timing_cfg_t      cfg_q;
  result_t          res, res_q;
  logic             out_vld_q;
  logic             stall, acc;
  mem_ctl_t         mem_ctl;
  logic [AW-1:0]    mem_addr;
  logic [ByteW-1:0] mem_wdata, mem_rdata;

  assign s_axis_tready_o = !stall && (!out_vld_q || m_axis_tready_i);
  assign acc             = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.leader_mark  <= LeaderMarkRst;
      cfg_q.leader_space <= LeaderSpaceRst;
      cfg_q.bit_mark     <= BitMarkRst;
      cfg_q.zero_space   <= ZeroSpaceRst;
      cfg_q.one_space    <= OneSpaceRst;
      cfg_q.stop_mark    <= StopMarkRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_LEADER_MARK:  cfg_q.leader_mark  <= cfg_wdata_i;
        REG_LEADER_SPACE: cfg_q.leader_space <= cfg_wdata_i;
        REG_BIT_MARK:     cfg_q.bit_mark     <= cfg_wdata_i;
        REG_ZERO_SPACE:   cfg_q.zero_space   <= cfg_wdata_i;
        REG_ONE_SPACE:    cfg_q.one_space    <= cfg_wdata_i;
        REG_STOP_MARK:    cfg_q.stop_mark    <= cfg_wdata_i;
        default:          ;  // drop writes beyond the register list
      endcase
    end
  end

  irpdt_seq #(
    .MAX_BYTES (MAX_BYTES),
    .AW        (AW)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .acc_i       (acc),
    .op_i        (s_axis_tuser_i),
    .data_i      (s_axis_tdata_i),
    .last_i      (s_axis_tlast_i),
    .cfg_i       (cfg_q),
    .stall_o     (stall),
    .res_o       (res),
    .mem_ctl_o   (mem_ctl),
    .mem_addr_o  (mem_addr),
    .mem_wdata_o (mem_wdata),
    .mem_rdata_i (mem_rdata)
  );

  irpdt_frame_mem #(
    .MAX_BYTES (MAX_BYTES),
    .AW        (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .ctl_i   (mem_ctl),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (acc) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {3'b000, res_q.status, res_q.done, res_q.busy, res_q.level};

`ifndef SYNTHESIS
  a_no_accept_on_fetch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall |-> !s_axis_tready_o)
    else $error("input beat taken during buffer fetch");

  a_done_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && res.done) |-> (res.busy && !res.level && !s_axis_tuser_i))
    else $error("frame end outside a stop mark tick");

  a_status_on_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && res.status != ST_OK) |-> s_axis_tuser_i)
    else $error("reject status on a tick beat");

  a_out_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> m_axis_tvalid_o)
    else $error("accepted beat produced no result");
`endif

endmodule
